[hw/rtl/htlm_pkg.sv]
`default_nettype none

package htlm_pkg;

    localparam int MAX_NODES     = 1024;
    localparam int USER_BITS     = 16;
    localparam int NODE_BITS     = $clog2(MAX_NODES);
    localparam int NCNT_BITS     = NODE_BITS + 1;
    localparam int BR_BITS       = 5;
    localparam int OP_BITS       = 2;
    localparam int SPAN_BITS     = NODE_BITS + BR_BITS;
    localparam int STEP_BITS     = $clog2(NODE_BITS + 1);
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = NCNT_BITS;

    localparam logic [BR_BITS-1:0]   BRANCH_MIN   = BR_BITS'(2);
    localparam logic [BR_BITS-1:0]   BRANCH_RESET = BR_BITS'(2);
    localparam logic [NCNT_BITS-1:0] NODES_MAX    = NCNT_BITS'(MAX_NODES);
    localparam logic [NCNT_BITS-1:0] NODES_RESET  = NCNT_BITS'(MAX_NODES);

    localparam logic [CFG_IDX_BITS-1:0] CFG_BRANCHING  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_COUNT = CFG_IDX_BITS'(1);

    typedef enum logic [OP_BITS-1:0] {
        OP_LOCK    = 2'd0,
        OP_UNLOCK  = 2'd1,
        OP_UPGRADE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ADDR_NODE,
        ADDR_CUR,
        ADDR_X,
        ADDR_CLR
    } addr_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLR,
        WR_LOCK,
        WR_UNLOCK,
        WR_ANC,
        WR_REL
    } wr_sel_t;

    typedef enum logic [1:0] {
        DELTA_INC,
        DELTA_DEC,
        DELTA_UPG
    } delta_sel_t;

    typedef struct packed {
        addr_sel_t  addr_sel;
        wr_sel_t    wr_sel;
        logic       load_item;
        logic       delta_load;
        delta_sel_t delta_sel;
        logic       cur_from_node;
        logic       cur_from_div;
        logic       div_start;
        logic       scan_init;
        logic       lvl_next;
        logic       x_from_lo;
        logic       x_inc;
        logic       clr_inc;
        logic       out_load;
        logic       out_grant;
    } cmd_t;

    typedef struct packed {
        logic [OP_BITS-1:0] opcode;
        logic               in_range;
        logic               rd_locked;
        logic               rd_cnt_zero;
        logic               owner_match;
        logic               cur_zero;
        logic               lo_past;
        logic               x_at_top;
        logic               div_done;
        logic               clr_last;
        logic               out_busy;
    } status_t;

endpackage

`default_nettype wire

[hw/rtl/htlm_req_if.sv]
`default_nettype none

interface htlm_req_if;
    logic                            valid;
    logic                            ready;
    logic [htlm_pkg::OP_BITS-1:0]    opcode;
    logic [htlm_pkg::NODE_BITS-1:0]  node_index;
    logic [htlm_pkg::USER_BITS-1:0]  user_id;

    modport source (output valid, output opcode, output node_index, output user_id,
                    input ready);
    modport sink (input valid, input opcode, input node_index, input user_id,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/htlm_rsp_if.sv]
`default_nettype none

interface htlm_rsp_if;
    logic valid;
    logic ready;
    logic granted;

    modport source (output valid, output granted, input ready);
    modport sink (input valid, input granted, output ready);
endinterface

`default_nettype wire

[hw/rtl/htlm_cfg_if.sv]
`default_nettype none

interface htlm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [htlm_pkg::CFG_IDX_BITS-1:0]   index;
    logic [htlm_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/htlm_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module htlm_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [htlm_pkg::NODE_BITS-1:0] dividend,
    input  wire logic [htlm_pkg::BR_BITS-1:0]   divisor,
    output logic                                done,
    output logic [htlm_pkg::NODE_BITS-1:0]      quotient
);
    import htlm_pkg::*;

    logic                   busy_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic [NODE_BITS-1:0]   quo_reg;
    logic [BR_BITS-1:0]     rem_reg;
    logic [BR_BITS:0]       rem_sh;
    logic                   fits;
    logic [BR_BITS:0]       rem_new;

    assign rem_sh   = {rem_reg, quo_reg[NODE_BITS-1]};
    assign fits     = rem_sh >= {1'b0, divisor};
    assign rem_new  = fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
    assign done     = busy_reg && (step_reg == '0);
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_BITS'(NODE_BITS);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg - STEP_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg && (step_reg != '0))
        begin
            quo_reg <= {quo_reg[NODE_BITS-2:0], fits};
            rem_reg <= rem_new[BR_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/htlm_datapath.sv]
`default_nettype none

module htlm_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_fire,
    input  wire logic [htlm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [htlm_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic [htlm_pkg::OP_BITS-1:0]      req_opcode,
    input  wire logic [htlm_pkg::NODE_BITS-1:0]    req_node,
    input  wire logic [htlm_pkg::USER_BITS-1:0]    req_user,
    input  wire logic                              rsp_ready,
    output logic                                   rsp_valid,
    output logic                                   rsp_granted,
    input  wire htlm_pkg::cmd_t                    cmd,
    output htlm_pkg::status_t                      status
);
    import htlm_pkg::*;

    // config
    logic [BR_BITS-1:0]   branch_reg;
    logic [NCNT_BITS-1:0] count_reg;
    logic [BR_BITS-1:0]   b_eff;
    logic [NCNT_BITS-1:0] n_eff;
    logic [NCNT_BITS-1:0] n_m1;

    // item
    logic [OP_BITS-1:0]   op_reg;
    logic [NODE_BITS-1:0] node_reg;
    logic [USER_BITS-1:0] user_reg;

    // walks
    logic [NODE_BITS-1:0] cur_reg;
    logic [NODE_BITS-1:0] delta_reg;
    logic [SPAN_BITS-1:0] lo_reg;
    logic [SPAN_BITS-1:0] hi_reg;
    logic [NODE_BITS-1:0] x_reg;
    logic [NODE_BITS-1:0] clr_reg;
    logic [SPAN_BITS-1:0] top_w;
    logic [NODE_BITS-1:0] mul_a;
    logic [SPAN_BITS-1:0] prod_a;
    logic [SPAN_BITS-1:0] prod_top;

    // storage: {locked, locked_below_count} and owner
    logic [NODE_BITS:0]   fc_mem  [MAX_NODES];
    logic [USER_BITS-1:0] own_mem [MAX_NODES];
    logic [NODE_BITS:0]   fc_rd_reg;
    logic [USER_BITS-1:0] own_rd_reg;
    logic [NODE_BITS-1:0] addr;
    logic                 fc_we;
    logic                 own_we;
    logic [NODE_BITS:0]   fc_wdata;

    logic                 div_done;
    logic [NODE_BITS-1:0] div_quo;

    logic                 out_valid_reg;
    logic                 out_grant_reg;

    assign b_eff = (branch_reg < BRANCH_MIN) ? BRANCH_MIN : branch_reg;
    assign n_eff = (count_reg > NODES_MAX) ? NODES_MAX : count_reg;
    assign n_m1  = n_eff - NCNT_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            branch_reg <= BRANCH_RESET;
            count_reg  <= NODES_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_BRANCHING:  branch_reg <= cfg_data[BR_BITS-1:0];
                CFG_NODE_COUNT: count_reg  <= cfg_data[NCNT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // level bounds of the descendant scan
    assign mul_a    = cmd.scan_init ? node_reg : lo_reg[NODE_BITS-1:0];
    assign prod_a   = SPAN_BITS'(mul_a) * SPAN_BITS'(b_eff);
    assign top_w    = (hi_reg < SPAN_BITS'(n_m1)) ? hi_reg : SPAN_BITS'(n_m1);
    assign prod_top = SPAN_BITS'(top_w[NODE_BITS-1:0]) * SPAN_BITS'(b_eff);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= req_opcode;
            node_reg <= req_node;
            user_reg <= req_user;
        end
        if (cmd.cur_from_node)
            cur_reg <= node_reg;
        else if (cmd.cur_from_div)
            cur_reg <= div_quo;
        if (cmd.delta_load)
        begin
            case (cmd.delta_sel)
                DELTA_INC: delta_reg <= NODE_BITS'(1);
                DELTA_DEC: delta_reg <= '1;
                DELTA_UPG: delta_reg <= NODE_BITS'(1) - fc_rd_reg[NODE_BITS-1:0];
                default:   delta_reg <= '0;
            endcase
        end
        if (cmd.scan_init)
        begin
            lo_reg <= prod_a + SPAN_BITS'(1);
            hi_reg <= prod_a + SPAN_BITS'(b_eff);
        end
        else if (cmd.lvl_next)
        begin
            lo_reg <= prod_a + SPAN_BITS'(1);
            hi_reg <= prod_top + SPAN_BITS'(b_eff);
        end
        if (cmd.x_from_lo)
            x_reg <= lo_reg[NODE_BITS-1:0];
        else if (cmd.x_inc)
            x_reg <= x_reg + NODE_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cfg_fire)
            clr_reg <= '0;
        else if (cmd.clr_inc)
            clr_reg <= clr_reg + NODE_BITS'(1);
    end

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_NODE: addr = node_reg;
            ADDR_CUR:  addr = cur_reg;
            ADDR_X:    addr = x_reg;
            ADDR_CLR:  addr = clr_reg;
            default:   addr = node_reg;
        endcase
    end

    always_comb
    begin
        fc_we    = 1'b1;
        own_we   = 1'b0;
        fc_wdata = '0;
        case (cmd.wr_sel)
            WR_CLR:    fc_wdata = '0;
            WR_LOCK:
            begin
                fc_wdata = {1'b1, {NODE_BITS{1'b0}}};
                own_we   = 1'b1;
            end
            WR_UNLOCK: fc_wdata = {1'b0, fc_rd_reg[NODE_BITS-1:0]};
            WR_ANC:    fc_wdata = {fc_rd_reg[NODE_BITS],
                                   fc_rd_reg[NODE_BITS-1:0] + delta_reg};
            WR_REL:    fc_wdata = '0;
            default:   fc_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fc_we)
            fc_mem[addr] <= fc_wdata;
        fc_rd_reg <= fc_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (own_we)
            own_mem[addr] <= user_reg;
        own_rd_reg <= own_mem[addr];
    end

    htlm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (cur_reg - NODE_BITS'(1)),
        .divisor  (b_eff),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_grant_reg <= cmd.out_grant;
    end

    assign rsp_valid   = out_valid_reg;
    assign rsp_granted = out_grant_reg;

    always_comb
    begin
        status.opcode      = op_reg;
        status.in_range    = {1'b0, node_reg} < n_eff;
        status.rd_locked   = fc_rd_reg[NODE_BITS];
        status.rd_cnt_zero = fc_rd_reg[NODE_BITS-1:0] == '0;
        status.owner_match = own_rd_reg == user_reg;
        status.cur_zero    = cur_reg == '0;
        status.lo_past     = lo_reg >= SPAN_BITS'(n_eff);
        status.x_at_top    = x_reg == top_w[NODE_BITS-1:0];
        status.div_done    = div_done;
        status.clr_last    = &clr_reg;
        status.out_busy    = out_valid_reg && !rsp_ready;
    end

endmodule

`default_nettype wire

[hw/rtl/htlm_ctrl.sv]
`default_nettype none

module htlm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_fire,
    input  wire logic              req_fire,
    output logic                   req_ready,
    input  wire htlm_pkg::status_t status,
    output htlm_pkg::cmd_t         cmd
);
    import htlm_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_NODE_RD = 13'b0000000000100,
        S_NODE_EV = 13'b0000000001000,
        S_ANC_TST = 13'b0000000010000,
        S_ANC_DIV = 13'b0000000100000,
        S_ANC_RD  = 13'b0000001000000,
        S_ANC_EV  = 13'b0000010000000,
        S_DSC_INI = 13'b0000100000000,
        S_DSC_LVL = 13'b0001000000000,
        S_DSC_RD  = 13'b0010000000000,
        S_DSC_EV  = 13'b0100000000000,
        S_RESULT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   upd_reg, upd_next;
    logic   rel_reg, rel_next;
    logic   grant_reg, grant_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            upd_reg   <= 1'b0;
            rel_reg   <= 1'b0;
            grant_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            upd_reg   <= upd_next;
            rel_reg   <= rel_next;
            grant_reg <= grant_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        upd_next   = upd_reg;
        rel_next   = rel_reg;
        grant_next = grant_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.addr_sel = ADDR_CLR;
                cmd.wr_sel   = WR_CLR;
                cmd.clr_inc  = 1'b1;
                if (status.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_fire)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_NODE_RD;
                end
            end
            S_NODE_RD:
            begin
                cmd.addr_sel = ADDR_NODE;
                state_next   = S_NODE_EV;
            end
            S_NODE_EV:
            begin
                cmd.addr_sel = ADDR_NODE;
                grant_next   = 1'b0;
                upd_next     = 1'b0;
                rel_next     = 1'b0;
                state_next   = S_RESULT;
                if (status.in_range)
                begin
                    case (opcode_t'(status.opcode))
                        OP_LOCK:
                        begin
                            if (!status.rd_locked && status.rd_cnt_zero)
                            begin
                                cmd.cur_from_node = 1'b1;
                                cmd.delta_load    = 1'b1;
                                cmd.delta_sel     = DELTA_INC;
                                state_next        = S_ANC_TST;
                            end
                        end
                        OP_UNLOCK:
                        begin
                            if (status.rd_locked && status.owner_match)
                            begin
                                cmd.wr_sel        = WR_UNLOCK;
                                cmd.cur_from_node = 1'b1;
                                cmd.delta_load    = 1'b1;
                                cmd.delta_sel     = DELTA_DEC;
                                upd_next          = 1'b1;
                                state_next        = S_ANC_TST;
                            end
                        end
                        OP_UPGRADE:
                        begin
                            if (!status.rd_locked && !status.rd_cnt_zero)
                            begin
                                cmd.cur_from_node = 1'b1;
                                cmd.delta_load    = 1'b1;
                                cmd.delta_sel     = DELTA_UPG;
                                state_next        = S_ANC_TST;
                            end
                        end
                        default: state_next = S_RESULT;
                    endcase
                end
            end
            S_ANC_TST:
            begin
                if (!status.cur_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_ANC_DIV;
                end
                else if (upd_reg)
                begin
                    grant_next = 1'b1;
                    state_next = S_RESULT;
                end
                else if (opcode_t'(status.opcode) == OP_LOCK)
                begin
                    // ancestors free: take the lock, then count it upward
                    cmd.addr_sel      = ADDR_NODE;
                    cmd.wr_sel        = WR_LOCK;
                    cmd.cur_from_node = 1'b1;
                    upd_next          = 1'b1;
                end
                else
                begin
                    state_next = S_DSC_INI;
                end
            end
            S_ANC_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.cur_from_div = 1'b1;
                    state_next       = S_ANC_RD;
                end
            end
            S_ANC_RD:
            begin
                cmd.addr_sel = ADDR_CUR;
                state_next   = S_ANC_EV;
            end
            S_ANC_EV:
            begin
                cmd.addr_sel = ADDR_CUR;
                state_next   = S_ANC_TST;
                if (upd_reg)
                    cmd.wr_sel = WR_ANC;
                else if (status.rd_locked)
                    state_next = S_RESULT;
            end
            S_DSC_INI:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_DSC_LVL;
            end
            S_DSC_LVL:
            begin
                if (!status.lo_past)
                begin
                    cmd.x_from_lo = 1'b1;
                    state_next    = S_DSC_RD;
                end
                else if (rel_reg)
                begin
                    cmd.addr_sel      = ADDR_NODE;
                    cmd.wr_sel        = WR_LOCK;
                    cmd.cur_from_node = 1'b1;
                    upd_next          = 1'b1;
                    state_next        = S_ANC_TST;
                end
                else
                begin
                    // owners all match: second pass frees the subtree
                    rel_next   = 1'b1;
                    state_next = S_DSC_INI;
                end
            end
            S_DSC_RD:
            begin
                cmd.addr_sel = ADDR_X;
                state_next   = S_DSC_EV;
            end
            S_DSC_EV:
            begin
                cmd.addr_sel = ADDR_X;
                if (rel_reg)
                    cmd.wr_sel = WR_REL;
                if (!rel_reg && status.rd_locked && !status.owner_match)
                    state_next = S_RESULT;
                else if (status.x_at_top)
                begin
                    cmd.lvl_next = 1'b1;
                    state_next   = S_DSC_LVL;
                end
                else
                begin
                    cmd.x_inc  = 1'b1;
                    state_next = S_DSC_RD;
                end
            end
            S_RESULT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_grant = grant_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
        if (cfg_fire)
            state_next = S_CLEAR;
    end

endmodule

`default_nettype wire

[hw/rtl/hierarchical_tree_lock_manager.sv]
`default_nettype none

// Channel  Dir  Transaction contents
// -------  ---  ----------------------------------------------------
// req      in   opcode (lock/unlock/upgrade), node_index, user_id
// rsp      out  granted
// cfg      in   index (0 branching, 1 node_count), data
//
// One request at a time. Each ancestor step runs the divider for the parent index
// plus test/read/evaluate; lock and upgrade walk the ancestors twice, unlock
// once. Upgrade adds up to two descendant scans: an owner check, then a release
// pass. The lock table is single-port. After reset and after every config write
// a clearing pass over all 1024 table entries runs with req.ready low;
// cfg.ready is always high. A new request is taken while the previous result
// waits on rsp.
module hierarchical_tree_lock_manager (
    input  wire logic   clk,
    input  wire logic   rst_n,
    htlm_req_if.sink    req,
    htlm_rsp_if.source  rsp,
    htlm_cfg_if.sink    cfg
);
    import htlm_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    req_fire;
    logic    cfg_fire;
    logic    req_ready;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid;   // ready tied high
    assign req.ready = req_ready;
    assign req_fire  = req.valid && req_ready;

    // sequencer: clear pass, ancestor walks, descendant scans
    htlm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_fire  (cfg_fire),
        .req_fire  (req_fire),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // lock/count/owner tables, walk registers, divider, result register
    htlm_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_fire    (cfg_fire),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .req_opcode  (req.opcode),
        .req_node    (req.node_index),
        .req_user    (req.user_id),
        .rsp_ready   (rsp.ready),
        .rsp_valid   (rsp.valid),
        .rsp_granted (rsp.granted),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

`default_nettype wire

[test/htlm_scoreboard.sv]
class htlm_scoreboard;
    bit    grant_q[$];
    int    errors;
    bit    flag_tbl[1024];
    int    owner_tbl[1024];
    int    below_cnt[1024];
    int    branch_eff;
    int    count_eff;

    function new();
        errors = 0;
        set_tree(2, 1024);
    endfunction

    function void set_tree(int br, int cnt);
        branch_eff = (br < 2) ? 2 : br;
        count_eff  = (cnt > 1024) ? 1024 : cnt;
        foreach (flag_tbl[k])
        begin
            flag_tbl[k]  = 0;
            owner_tbl[k] = 0;
            below_cnt[k] = 0;
        end
    endfunction

    function bit anc_held(int idx);
        while (idx != 0)
        begin
            idx = (idx - 1) / branch_eff;
            if (flag_tbl[idx])
                return 1;
        end
        return 0;
    endfunction

    function void bump_anc(int idx, int delta);
        while (idx != 0)
        begin
            idx = (idx - 1) / branch_eff;
            below_cnt[idx] += delta;
        end
    endfunction

    // level-order descendant scan; release frees every locked one
    function bit scan_below(int idx, int user, bit release_all);
        longint lo;
        longint hi;
        longint top;
        lo = longint'(idx) * branch_eff + 1;
        hi = longint'(idx) * branch_eff + branch_eff;
        while (lo < count_eff)
        begin
            top = (hi < count_eff - 1) ? hi : count_eff - 1;
            for (longint x = lo; x <= top; x++)
            begin
                if (!flag_tbl[x])
                    continue;
                if (release_all)
                begin
                    flag_tbl[x] = 0;
                    bump_anc(int'(x), -1);
                end
                else if (owner_tbl[x] != user)
                    return 0;
            end
            lo = lo * branch_eff + 1;
            hi = hi * branch_eff + branch_eff;
        end
        return 1;
    endfunction

    function void note_request(logic [1:0] op, int idx, int user);
        bit ok;
        ok = 0;
        if (idx < count_eff)
        begin
            if (op == htlm_pkg::OP_LOCK)
            begin
                if (!flag_tbl[idx] && below_cnt[idx] == 0 && !anc_held(idx))
                    ok = 1;
            end
            else if (op == htlm_pkg::OP_UNLOCK)
            begin
                if (flag_tbl[idx] && owner_tbl[idx] == user)
                begin
                    flag_tbl[idx] = 0;
                    bump_anc(idx, -1);
                    ok = 1;
                end
            end
            else if (op == htlm_pkg::OP_UPGRADE)
            begin
                if (!flag_tbl[idx] && below_cnt[idx] != 0 && !anc_held(idx)
                    && scan_below(idx, user, 0))
                begin
                    void'(scan_below(idx, user, 1));
                    ok = 1;
                end
            end
            if (ok && op != htlm_pkg::OP_UNLOCK)
            begin
                flag_tbl[idx]  = 1;
                owner_tbl[idx] = user;
                bump_anc(idx, 1);
            end
        end
        grant_q = {grant_q, ok};
    endfunction

    function void check_grant(logic got);
        bit want;
        if (grant_q.size() == 0)
        begin
            $error("granted: no result expected, actual %0d", got);
            errors++;
            return;
        end
        want = grant_q.pop_front();
        if (got !== want)
        begin
            $error("granted: expected %0d actual %0d", want, got);
            errors++;
        end
    endfunction
endclass

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import htlm_pkg::*;

    logic clk;
    logic rst_n;
    longint cycle_cnt;

    htlm_req_if req ();
    htlm_rsp_if rsp ();
    htlm_cfg_if cfg ();

    hierarchical_tree_lock_manager uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    htlm_scoreboard lock_sb;

    // Most gaps short, a few long.
    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Global watchdog: the slowest upgrade over the full tree scans ~2k nodes
    // plus ancestor walks; the limit allows for that per item, plus clearing passes.
    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > 40_000_000)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Response side: random back-pressure, each accepted transaction is checked.
    logic stall_en;
    initial
    begin
        int wait_n;
        rsp.ready = 0;
        stall_en  = 1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
                lock_sb.check_grant(rsp.granted);
            if (stall_en && $urandom_range(0, 3) == 0)
            begin
                wait_n = gap_len();
                if (wait_n > 0)
                begin
                    rsp.ready <= 0;
                    repeat (wait_n) @(posedge clk);
                end
                rsp.ready <= 1;
            end
            else
                rsp.ready <= 1;
        end
    end

    // One request transaction; scoreboard prediction at acceptance.
    // Valid stays high afterwards; pause_req or drain drops it.
    task automatic send_req(logic [1:0] op, logic [9:0] idx, logic [15:0] user);
        req.valid      <= 1;
        req.opcode     <= op;
        req.node_index <= idx;
        req.user_id    <= user;
        do @(posedge clk); while (!(req.valid && req.ready));
        lock_sb.note_request(op, idx, user);
    endtask

    // Idle pause between requests; a zero gap keeps valid high so
    // back-to-back traffic also happens.
    task automatic pause_req();
        int n;
        n = gap_len();
        if (n > 0)
        begin
            req.valid <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Wait for every expected grant, then let the block settle.
    task automatic drain();
        req.valid <= 0;
        while (lock_sb.grant_q.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    // Register write; clears all lock state in both block and model.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int value, int br, int cnt);
        drain();
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data  <= value[CFG_DATA_BITS-1:0];
        do @(posedge clk); while (!(cfg.valid && cfg.ready));
        cfg.valid <= 0;
        lock_sb.set_tree(br, cnt);
    endtask

    // Random item: node biased toward the tree, users from a small pool so
    // ownership matches happen; rare full-range values hit every bit.
    task automatic rand_req(int cnt);
        logic [1:0]  op;
        logic [9:0]  idx;
        logic [15:0] user;
        int          sel;
        sel  = $urandom_range(0, 19);
        op   = (sel == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        if (sel == 1 || cnt == 0)
            idx = 10'($urandom_range(0, 1023));
        else if ($urandom_range(0, 2) == 0)
            idx = 10'($urandom_range(0, (cnt > 8 ? 8 : cnt) - 1));
        else
            idx = 10'($urandom_range(0, (cnt > 1024 ? 1024 : cnt) - 1));
        user = (sel == 2) ? 16'($urandom) : 16'($urandom_range(0, 2) * 16'h5A5A);
        send_req(op, idx, user);
        pause_req();
    endtask

    initial
    begin
        int br_set[6];
        int cnt_set[6];
        lock_sb = new();
        rst_n = 0;
        req.valid = 0;
        req.opcode = OP_LOCK;
        req.node_index = 0;
        req.user_id = 0;
        cfg.valid = 0;
        cfg.index = CFG_BRANCHING;
        cfg.data = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reset tree (branching 2, 1024 nodes).
        send_req(OP_LOCK, 10'd3, 16'hFFFF);       // lock a node
        send_req(OP_LOCK, 10'd1, 16'hFFFF);       // ancestor with locked descendant
        send_req(OP_LOCK, 10'd7, 16'hFFFF);       // locked ancestor
        send_req(OP_UNLOCK, 10'd3, 16'h0000);     // wrong user
        send_req(OP_UPGRADE, 10'd1, 16'h0000);    // foreign descendant
        send_req(OP_LOCK, 10'd4, 16'hFFFF);
        send_req(OP_UPGRADE, 10'd0, 16'hFFFF);    // upgrade to root
        send_req(OP_UPGRADE, 10'd2, 16'hFFFF);    // ancestor locked
        send_req(OP_UNLOCK, 10'd0, 16'hFFFF);
        send_req(OP_UPGRADE, 10'd5, 16'h1234);    // nothing locked below
        send_req(OP_LOCK, 10'd1023, 16'h0000);    // deepest leaf
        send_req(2'd3, 10'd1023, 16'h0000);       // unknown opcode
        send_req(OP_UNLOCK, 10'd1023, 16'h0000);
        send_req(OP_UNLOCK, 10'd1023, 16'h0000);  // already free
        drain();                                  // sender holds until all results seen

        // Extremes: branching below minimum, count 0 and above maximum.
        write_reg(CFG_BRANCHING, 0, 0, 1024);
        send_req(OP_LOCK, 10'd2, 16'h00FF);
        write_reg(CFG_NODE_COUNT, 0, 0, 0);
        send_req(OP_LOCK, 10'd0, 16'h00FF);       // no node exists
        write_reg(CFG_NODE_COUNT, 2047, 0, 2047);
        send_req(OP_LOCK, 10'd1023, 16'h00FF);
        write_reg(CFG_BRANCHING, 31, 31, 2047);
        send_req(OP_LOCK, 10'd40, 16'h0001);
        send_req(OP_UPGRADE, 10'd1, 16'h0001);
        write_reg(CFG_NODE_COUNT, 1, 31, 1);
        send_req(OP_LOCK, 10'd1, 16'h0001);       // out of tree
        send_req(OP_LOCK, 10'd0, 16'h0001);

        // Random phases over several tree shapes.
        br_set  = '{2, 3, 30, 1, 5, 2};
        cnt_set = '{13, 100, 1024, 40, 700, 31};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_BRANCHING, br_set[ph], br_set[ph], lock_sb.count_eff);
            write_reg(CFG_NODE_COUNT, cnt_set[ph], br_set[ph], cnt_set[ph]);
            stall_en = (ph != 2);   // one phase with no receiver stalls
            for (int k = 0; k < 290; k++)
                rand_req(cnt_set[ph]);
        end

        drain();
        if (lock_sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
